### sv/gmfp_pkg.sv
package gmfp_pkg;

  // Field and register widths.
  localparam int SAMPLE_W  = 8;
  localparam int PROD_W    = 32;
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int ROW_W     = 10;

  // Size limits and reset values of the size registers.
  localparam int ROW_LIMIT        = 1024;
  localparam int ROW_RESET        = 20;
  localparam int COL_RESET        = 20;
  localparam int MAX_COLS_DEFAULT = 1024;

  // The line store keeps this many rows above the current one.
  localparam int LINES = 3;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;

  // Sequencer step counter and the last step of each phase.
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] READ_LAST     = 3'd2;
  localparam logic [STEP_W-1:0] FEED_LAST     = 3'd3;
  localparam logic [STEP_W-1:0] MUL_LAST      = 3'd6;
  localparam logic [STEP_W-1:0] WRITE_LAST    = 3'd3;

  // Which column set the line store is read at.
  typedef enum logic [1:0] {
    PH_VERT = 2'd0,
    PH_DIAG = 2'd1,
    PH_ANTI = 2'd2
  } phase_t;

  // Which run of four goes into the multiply pipeline.
  typedef enum logic [1:0] {
    RUN_HORZ = 2'd0,
    RUN_VERT = 2'd1,
    RUN_DIAG = 2'd2,
    RUN_ANTI = 2'd3
  } run_t;

  typedef struct packed {
    logic       load;
    logic       rd_en;
    phase_t     rd_phase;
    logic       cap_en;
    phase_t     cap_phase;
    logic       feed;
    run_t       run;
    logic       wr_en;
    logic [1:0] wr_off;
    logic       advance;
  } gmfp_cmd_t;

  typedef struct packed {
    logic row_end;
    logic frame_end;
    logic out_busy;
  } gmfp_status_t;

  // Line store slot that holds the row 'back' rows above (back is 1 to 3).
  function automatic logic [1:0] slot_of_back(input logic [1:0] cur, input logic [1:0] back);
    logic [2:0] t;
    t = {1'b0, cur} + 3'd3 - {1'b0, back};
    return (t >= 3'd3) ? 2'(t - 3'd3) : 2'(t);
  endfunction

  // How many rows above the current one a slot holds (1 to 3).
  function automatic logic [1:0] back_of_slot(input logic [1:0] cur, input logic [1:0] slot);
    logic [2:0] t;
    t = {1'b0, cur} + 3'd3 - {1'b0, slot};
    return (t > 3'd3) ? 2'(t - 3'd3) : 2'(t);
  endfunction

endpackage

### sv/gmfp_in_if.sv
interface gmfp_in_if import gmfp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source(output valid, output sample, input ready);
  modport sink(input valid, input sample, output ready);
endinterface

### sv/gmfp_out_if.sv
interface gmfp_out_if import gmfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PROD_W-1:0] max_product;

  modport source(output valid, output max_product, input ready);
  modport sink(input valid, input max_product, output ready);
endinterface

### sv/gmfp_ram.sv
module gmfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/gmfp_ctrl.sv
module gmfp_ctrl import gmfp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  gmfp_status_t status,
  output logic         ready,
  output gmfp_cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_MUL   = 5'b00100,
    S_WRITE = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    ready      = 1'b0;
    case (state)
      S_IDLE: begin
        ready = 1'b1;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_READ;
          step_next  = '0;
        end
      end
      S_READ: begin
        // One read pass per column set, captured on the next step.
        cmd.rd_en    = 1'b1;
        cmd.rd_phase = phase_t'(step[1:0]);
        if (step != '0) begin
          cmd.cap_en    = 1'b1;
          cmd.cap_phase = phase_t'(step[1:0] - 2'd1);
        end
        if (step == READ_LAST) begin
          state_next = S_MUL;
          step_next  = '0;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_MUL: begin
        if (step == '0) begin
          cmd.cap_en    = 1'b1;
          cmd.cap_phase = PH_ANTI;
        end
        if (step <= FEED_LAST) begin
          cmd.feed = 1'b1;
          cmd.run  = run_t'(step[1:0]);
        end
        if (step == MUL_LAST) begin
          state_next = S_WRITE;
          step_next  = '0;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_WRITE: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_off = 2'(WRITE_LAST - step);
        if (step == WRITE_LAST || !status.row_end) begin
          state_next = S_DONE;
          step_next  = '0;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_DONE: begin
        if (!(status.frame_end && status.out_busy)) begin
          cmd.advance = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
        step_next  = '0;
      end
    endcase
  end

endmodule

### sv/gmfp_datapath.sv
module gmfp_datapath import gmfp_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic [SAMPLE_W-1:0]  sample,
  input  gmfp_cmd_t            cmd,
  output gmfp_status_t         status,
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic [PROD_W-1:0]    max_product
);

  localparam int AW = $clog2(MAX_COLS);
  localparam int CW = $clog2(MAX_COLS) + 2;

  logic [CFG_W-1:0]    row_count, col_count;
  logic [CFG_W-1:0]    rows_eff;
  logic [CW-1:0]       cols_eff;
  logic [ROW_W-1:0]    row_index;
  logic [CW-1:0]       col_index;
  logic [1:0]          slot;
  logic [PROD_W-1:0]   best;
  logic [SAMPLE_W-1:0] sample_q;
  logic [SAMPLE_W-1:0] tail [LINES];
  logic [SAMPLE_W-1:0] cap [LINES][LINES];
  logic [SAMPLE_W-1:0] rdata [LINES];

  logic cfg_hit, row_end, frame_end, c_ge1, c_ge2, c_ge3, r_ge3, anti_fits;

  always_comb begin
    if (row_count == '0) begin
      rows_eff = CFG_W'(1);
    end else if (int'(row_count) > ROW_LIMIT) begin
      rows_eff = CFG_W'(ROW_LIMIT);
    end else begin
      rows_eff = row_count;
    end
    if (col_count == '0) begin
      cols_eff = CW'(1);
    end else if (int'(col_count) > MAX_COLS) begin
      cols_eff = CW'(MAX_COLS);
    end else begin
      cols_eff = CW'(col_count);
    end
  end

  assign cfg_hit   = cfg_we && (cfg_index == REG_ROW_COUNT || cfg_index == REG_COL_COUNT);
  assign row_end   = (col_index + CW'(1)) >= cols_eff;
  assign frame_end = row_end && ((CFG_W'(row_index) + CFG_W'(1)) >= rows_eff);
  assign c_ge1     = col_index >= CW'(1);
  assign c_ge2     = col_index >= CW'(2);
  assign c_ge3     = col_index >= CW'(3);
  assign r_ge3     = row_index >= ROW_W'(3);
  assign anti_fits = (col_index + CW'(3)) < cols_eff;

  assign status.row_end   = row_end;
  assign status.frame_end = frame_end;
  assign status.out_busy  = result_valid && !result_ready;

  // Write side: only the current row's slot is written, some columns late.
  logic                wr_ok;
  logic [SAMPLE_W-1:0] wr_data;
  logic [AW-1:0]       wr_addr;

  always_comb begin
    wr_addr = AW'(col_index - CW'(cmd.wr_off));
    case (cmd.wr_off)
      2'd3: begin
        wr_ok   = c_ge3;
        wr_data = tail[2];
      end
      2'd2: begin
        wr_ok   = c_ge2 && row_end;
        wr_data = tail[1];
      end
      2'd1: begin
        wr_ok   = c_ge1 && row_end;
        wr_data = tail[0];
      end
      default: begin
        wr_ok   = row_end;
        wr_data = sample_q;
      end
    endcase
  end

  for (genvar k = 0; k < LINES; k++) begin : g_line
    logic [1:0]    back;
    logic [AW-1:0] raddr;

    always_comb begin
      back = back_of_slot(slot, 2'(k));
      case (cmd.rd_phase)
        PH_DIAG: raddr = AW'(col_index - CW'(back));
        PH_ANTI: raddr = AW'(col_index + CW'(back));
        default: raddr = AW'(col_index);
      endcase
    end

    gmfp_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(MAX_COLS)
    ) u_ram (
      .clk  (clk),
      .we   (cmd.wr_en && wr_ok && (slot == 2'(k))),
      .waddr(wr_addr),
      .wdata(wr_data),
      .re   (cmd.rd_en),
      .raddr(raddr),
      .rdata(rdata[k])
    );
  end

  // Captured reads, ordered by rows above (one row up first).
  always_ff @(posedge clk) begin
    if (cmd.cap_en) begin
      for (int b = 0; b < LINES; b++) begin
        cap[cmd.cap_phase][b] <= rdata[slot_of_back(slot, 2'(b + 1))];
      end
    end
  end

  // Operand selection for the run fed into the pipeline.
  logic [SAMPLE_W-1:0] x1, x2, x3;
  logic                run_ok;

  always_comb begin
    case (cmd.run)
      RUN_VERT: begin
        x1 = cap[PH_VERT][0]; x2 = cap[PH_VERT][1]; x3 = cap[PH_VERT][2];
        run_ok = r_ge3;
      end
      RUN_DIAG: begin
        x1 = cap[PH_DIAG][0]; x2 = cap[PH_DIAG][1]; x3 = cap[PH_DIAG][2];
        run_ok = r_ge3 && c_ge3;
      end
      RUN_ANTI: begin
        x1 = cap[PH_ANTI][0]; x2 = cap[PH_ANTI][1]; x3 = cap[PH_ANTI][2];
        run_ok = r_ge3 && anti_fits;
      end
      default: begin
        x1 = tail[0]; x2 = tail[1]; x3 = tail[2];
        run_ok = c_ge3;
      end
    endcase
  end

  // Three-stage multiply pipeline: two bytes first, then one byte per stage.
  logic [2*SAMPLE_W-1:0] p1;
  logic [3*SAMPLE_W-1:0] p2;
  logic [PROD_W-1:0]     p3;
  logic [SAMPLE_W-1:0]   s1_x2, s1_x3, s2_x3;
  logic                  v1, v2, v3;

  always_ff @(posedge clk) begin
    p1    <= (2*SAMPLE_W)'(sample_q) * (2*SAMPLE_W)'(x1);
    s1_x2 <= x2;
    s1_x3 <= x3;
    p2    <= (3*SAMPLE_W)'(p1) * (3*SAMPLE_W)'(s1_x2);
    s2_x3 <= s1_x3;
    p3    <= PROD_W'(p2) * PROD_W'(s2_x3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.feed && run_ok;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_q <= sample;
    end
    if (cmd.advance && !row_end) begin
      tail[2] <= tail[1];
      tail[1] <= tail[0];
      tail[0] <= sample_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= CFG_W'(ROW_RESET);
      col_count <= CFG_W'(COL_RESET);
      row_index <= '0;
      col_index <= '0;
      slot      <= '0;
      best      <= '0;
    end else if (cfg_hit) begin
      if (cfg_index == REG_ROW_COUNT) begin
        row_count <= cfg_data;
      end else begin
        col_count <= cfg_data;
      end
      row_index <= '0;
      col_index <= '0;
      slot      <= '0;
      best      <= '0;
    end else if (cmd.advance) begin
      if (row_end) begin
        col_index <= '0;
        if (frame_end) begin
          row_index <= '0;
          slot      <= '0;
          best      <= '0;
        end else begin
          row_index <= row_index + 1'b1;
          slot      <= (slot == 2'(LINES - 1)) ? 2'd0 : slot + 2'd1;
        end
      end else begin
        col_index <= col_index + 1'b1;
      end
    end else if (v3 && p3 > best) begin
      best <= p3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.advance && frame_end) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.advance && frame_end) begin
      max_product <= best;
    end
  end

endmodule

### sv/grid_max_four_product.sv
// Largest product of four adjacent grid samples in a line, per frame.
//
// The grid channel takes one unsigned 8-bit sample per request, in raster
// order. The frame size comes from the row_count and col_count registers,
// which the user must write on the plain write port only while the block
// is idle; the block itself does not enforce this. Any write to either
// register abandons the frame in progress and clears the running maximum.
// After the last sample of a frame, the result channel carries one request
// with the largest product over all horizontal, vertical, diagonal and
// anti-diagonal runs of four that fit in the grid, or zero if none fits.
// Each sample is worked through before the next one is accepted, and the
// last column of a row takes longer. This work is three read passes over
// the line store memories, the three-stage multiply pipeline that the four
// runs flow through one after another, and up to four single-port writes
// of the delayed row samples at row end. The result is registered once
// the last sample of a frame is done. Reset returns the size registers to
// 20 by 20 and clears all control state; the line store needs no clearing.
// The result sits in an output register: under a stalled receiver the next
// frame still goes in, and the block waits after its last sample.
module grid_max_four_product import gmfp_pkg::*; #(
  parameter int MAX_COLS = MAX_COLS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  gmfp_in_if.sink              grid,
  gmfp_out_if.source           result
);

  gmfp_cmd_t    cmd;
  gmfp_status_t status;
  logic         ready;

  // The sequencer owns the grid handshake: one sample is worked at a time.
  assign grid.ready = ready;

  gmfp_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (grid.valid && ready),
    .status(status),
    .ready (ready),
    .cmd   (cmd)
  );

  // The datapath holds the size registers, position counters, line store,
  // multiply pipeline, running maximum and the output register.
  gmfp_datapath #(
    .MAX_COLS(MAX_COLS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample      (grid.sample),
    .cmd         (cmd),
    .status      (status),
    .result_valid(result.valid),
    .result_ready(result.ready),
    .max_product (result.max_product)
  );

endmodule
